// ----- design/assert_macros.svh -----
// Assertion macros shared by the validator RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MCV_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/mcv_pkg.sv -----
// Types, codes and constants for the microcode image validator.
// No dependencies; used by mcv_capture, mcv_verdict and the top level.
package mcv_pkg;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_VERSION   = 4'd2;
    localparam logic [3:0] ST_SIGNATURE = 4'd3;
    localparam logic [3:0] ST_PLATFORM  = 4'd4;
    localparam logic [3:0] ST_SIZE      = 4'd5;
    localparam logic [3:0] ST_CHECKSUM  = 4'd6;
    localparam logic [3:0] ST_TRUNCATED = 4'd7;
    localparam logic [3:0] ST_REJECT    = 4'd8;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_LAYOUT1 = 2'd1;
    localparam logic [1:0] MODE_LAYOUT2 = 2'd2;

    localparam logic [1:0] REG_VENDOR_MODE        = 2'd0;
    localparam logic [1:0] REG_CPU_SIGNATURE      = 2'd1;
    localparam logic [1:0] REG_PLATFORM_MASK      = 2'd2;
    localparam logic [1:0] REG_INSTALLED_REVISION = 2'd3;

    localparam int HW_VERSION     = 0;
    localparam int HW_REVISION    = 1;
    localparam int HW_SIGNATURE   = 3;
    localparam int HW_PLATFORM    = 6;
    localparam int HW_PAYLOAD_LEN = 7;
    localparam int HW_IMAGE_LEN   = 8;
    localparam int HDR_WORDS      = 9;
    localparam int PREFIX_SLOTS   = 7;
    localparam int MIN_WORDS      = 12;

    localparam logic [31:0] HDR_VERSION_ONE    = 32'h0000_0001;
    localparam logic [31:0] DEFAULT_SPAN_BYTES = 32'd2048;
    localparam logic [31:0] PAYLOAD_LEN_MIN    = 32'd2000;
    localparam logic [31:0] PAYLOAD_LEN_MAX    = 32'd32000;
    localparam logic [31:0] IMAGE_LEN_MIN      = 32'd2048;
    localparam logic [31:0] IMAGE_LEN_MAX      = 32'd32768;

    typedef struct packed {
        logic        too_short;
        logic        truncated;
        logic        sum_zero;
        logic [31:0] version;
        logic [31:0] signature;
        logic [31:0] platform;
        logic [31:0] payload_len;
        logic [31:0] image_len;
        logic [31:0] revision;
    } hdr_view_t;

    function automatic logic [15:0] rev_id(input logic [31:0] sig);
        logic [8:0] fam;
        logic [7:0] mdl;
        fam = {5'd0, sig[11:8]};
        mdl = {4'd0, sig[7:4]};
        if (fam >= 9'd15) begin
            fam = fam + {1'b0, sig[27:20]};
        end
        if (fam >= 9'd15 || (fam == 9'd6 && mdl >= 8'd15)) begin
            mdl = mdl + {sig[19:16], 4'd0};
        end
        return {fam[3:0], mdl, sig[3:0]};
    endfunction

endpackage

// ----- design/microcode_image_validator_unit.sv -----
// Microcode image validator: one verdict beat per image, issued at its last word.
// The verdict is registered onto m_* when the final beat leaves the input register.
// Throughput: one word beat per cycle; a final beat waits in the input register
// only while the previous verdict is still held on m_* by m_tready low.
// Reset (aresetn, synchronous, active low) clears configuration and image state.
`include "assert_macros.svh"
module microcode_image_validator_unit #(
    parameter int MAX_IMAGE_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] image_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] accepted, [4:1] status, [36:5] update revision, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [1:0]  vendor_mode_reg;
    logic [31:0] cpu_signature_reg;
    logic [7:0]  platform_mask_reg;
    logic [31:0] installed_revision_reg;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        in_last_reg;
    logic        advance;

    logic        out_valid_reg;
    logic        out_accepted_reg;
    logic [3:0]  out_status_reg;
    logic [31:0] out_revision_reg;

    mcv_pkg::hdr_view_t view;
    logic [3:0]         status;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'd0, out_revision_reg, out_status_reg, out_accepted_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_mode_reg        <= mcv_pkg::MODE_NONE;
            cpu_signature_reg      <= '0;
            platform_mask_reg      <= '0;
            installed_revision_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mcv_pkg::REG_VENDOR_MODE:        vendor_mode_reg        <= cfg_wdata[1:0];
                mcv_pkg::REG_CPU_SIGNATURE:      cpu_signature_reg      <= cfg_wdata;
                mcv_pkg::REG_PLATFORM_MASK:      platform_mask_reg      <= cfg_wdata[7:0];
                mcv_pkg::REG_INSTALLED_REVISION: installed_revision_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mcv_capture #(
        .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
    ) u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .word    (in_word_reg),
        .last    (in_last_reg),
        .view    (view)
    );

    mcv_verdict u_verdict (
        .view               (view),
        .vendor_mode        (vendor_mode_reg),
        .cpu_signature      (cpu_signature_reg),
        .platform_mask      (platform_mask_reg),
        .installed_revision (installed_revision_reg),
        .status             (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_accepted_reg <= status == mcv_pkg::ST_OK;
            out_status_reg   <= status;
            out_revision_reg <= view.revision;
        end
    end

    `MCV_ASSERT(a_accept_matches_status, aclk, aresetn, out_valid_reg |-> (out_accepted_reg == (out_status_reg == mcv_pkg::ST_OK)), "accepted flag disagrees with status")
    `MCV_ASSERT_NEXT(a_no_verdict_without_last, aclk, aresetn, (!out_valid_reg || m_tready) && !(advance && in_last_reg), !out_valid_reg, "verdict beat without a final word")
    `MCV_ASSERT_NEXT(a_final_word_held, aclk, aresetn, in_valid_reg && in_last_reg && !advance, in_valid_reg && in_last_reg, "final word dropped while output stalled")

endmodule

// ----- design/mcv_capture.sv -----
// Header capture, word counter and running checksum for one image.
// Depends on mcv_pkg; feeds a hdr_view_t to mcv_verdict.
module mcv_capture #(
    parameter int MAX_IMAGE_BYTES = 32768
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [31:0]        word,
    input  logic               last,
    output mcv_pkg::hdr_view_t view
);

    localparam int CAP      = MAX_IMAGE_BYTES / 4 + 1;
    localparam int SPAN_MAX = MAX_IMAGE_BYTES / 4;
    localparam int CNT_W    = $clog2(CAP + 1);

    logic [CNT_W-1:0] wc_reg, wc_next;
    logic [CNT_W-1:0] span_reg, span_next;
    logic [31:0]      word_sum_reg, word_sum_next;
    logic [31:0]      revision_reg, revision_next;
    logic [31:0]      version_reg, signature_reg, platform_reg;
    logic [31:0]      payload_len_reg, image_len_reg;
    logic [31:0]      prefix_reg [mcv_pkg::PREFIX_SLOTS];

    logic [31:0]      span_bytes;
    logic [29:0]      span_raw;
    logic [CNT_W-1:0] span_sat;
    logic [3:0]       n_hdr;
    logic [31:0]      hdr_sum;
    logic [2:0]       prefix_sel;

    always_comb begin
        span_bytes = (word == 32'd0) ? mcv_pkg::DEFAULT_SPAN_BYTES : word;
        span_raw   = span_bytes[31:2];
        span_sat   = (span_raw > 30'(CAP)) ? CNT_W'(CAP) : span_raw[CNT_W-1:0];
        n_hdr      = (span_raw >= 30'(mcv_pkg::HDR_WORDS)) ? 4'(mcv_pkg::HDR_WORDS)
                                                           : span_raw[3:0];
        prefix_sel = 3'(n_hdr - 4'd1);
        if (n_hdr == 4'd0) begin
            hdr_sum = 32'd0;
        end else if (n_hdr == 4'(mcv_pkg::HDR_WORDS)) begin
            hdr_sum = word_sum_reg + word;
        end else if (n_hdr == 4'(mcv_pkg::HW_IMAGE_LEN)) begin
            hdr_sum = word_sum_reg;
        end else begin
            hdr_sum = prefix_reg[prefix_sel];
        end
    end

    always_comb begin
        wc_next       = (wc_reg < CNT_W'(CAP)) ? wc_reg + CNT_W'(1) : wc_reg;
        span_next     = span_reg;
        revision_next = (wc_reg == CNT_W'(mcv_pkg::HW_REVISION)) ? word : revision_reg;
        if (wc_reg < CNT_W'(mcv_pkg::HW_IMAGE_LEN)) begin
            word_sum_next = word_sum_reg + word;
        end else if (wc_reg == CNT_W'(mcv_pkg::HW_IMAGE_LEN)) begin
            word_sum_next = hdr_sum;
            span_next     = span_sat;
        end else if (wc_reg < span_reg) begin
            word_sum_next = word_sum_reg + word;
        end else begin
            word_sum_next = word_sum_reg;
        end
    end

    always_comb begin
        view.too_short   = wc_next < CNT_W'(mcv_pkg::MIN_WORDS);
        view.truncated   = (span_next > CNT_W'(SPAN_MAX)) || (wc_next < span_next);
        view.sum_zero    = word_sum_next == 32'd0;
        view.version     = version_reg;
        view.signature   = signature_reg;
        view.platform    = platform_reg;
        view.payload_len = payload_len_reg;
        view.image_len   = image_len_reg;
        view.revision    = revision_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg       <= '0;
            span_reg     <= CNT_W'(mcv_pkg::DEFAULT_SPAN_BYTES >> 2);
            word_sum_reg <= '0;
            revision_reg <= '0;
        end else if (advance) begin
            if (last) begin
                wc_reg       <= '0;
                span_reg     <= CNT_W'(mcv_pkg::DEFAULT_SPAN_BYTES >> 2);
                word_sum_reg <= '0;
                revision_reg <= '0;
            end else begin
                wc_reg       <= wc_next;
                span_reg     <= span_next;
                word_sum_reg <= word_sum_next;
                revision_reg <= revision_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (wc_reg < CNT_W'(mcv_pkg::PREFIX_SLOTS)) begin
                prefix_reg[wc_reg[2:0]] <= word_sum_reg + word;
            end
            if (wc_reg == CNT_W'(mcv_pkg::HW_VERSION)) begin
                version_reg <= word;
            end
            if (wc_reg == CNT_W'(mcv_pkg::HW_SIGNATURE)) begin
                signature_reg <= word;
            end
            if (wc_reg == CNT_W'(mcv_pkg::HW_PLATFORM)) begin
                platform_reg <= word;
            end
            if (wc_reg == CNT_W'(mcv_pkg::HW_PAYLOAD_LEN)) begin
                payload_len_reg <= word;
            end
            if (wc_reg == CNT_W'(mcv_pkg::HW_IMAGE_LEN)) begin
                image_len_reg <= word;
            end
        end
    end

endmodule

// ----- design/mcv_verdict.sv -----
// Ordered check chain that turns a captured header view into a status code.
// Depends on mcv_pkg; driven by mcv_capture and the configuration registers.
module mcv_verdict (
    input  mcv_pkg::hdr_view_t view,
    input  logic [1:0]         vendor_mode,
    input  logic [31:0]        cpu_signature,
    input  logic [7:0]         platform_mask,
    input  logic [31:0]        installed_revision,
    output logic [3:0]         status
);

    logic [15:0] expected_id;
    logic        size_bad;
    logic        newer;

    always_comb begin
        expected_id = mcv_pkg::rev_id(cpu_signature);
        newer       = view.revision > installed_revision;
        if (view.payload_len == 32'd0) begin
            size_bad = view.image_len < mcv_pkg::IMAGE_LEN_MIN
                    || view.image_len > mcv_pkg::IMAGE_LEN_MAX;
        end else begin
            size_bad = view.payload_len < mcv_pkg::PAYLOAD_LEN_MIN
                    || view.payload_len > mcv_pkg::PAYLOAD_LEN_MAX;
        end
    end

    always_comb begin
        status = mcv_pkg::ST_OK;
        if (vendor_mode != mcv_pkg::MODE_LAYOUT1 && vendor_mode != mcv_pkg::MODE_LAYOUT2) begin
            status = mcv_pkg::ST_REJECT;
        end else if (view.too_short) begin
            status = mcv_pkg::ST_SHORT;
        end else if (view.version != mcv_pkg::HDR_VERSION_ONE) begin
            status = mcv_pkg::ST_VERSION;
        end else if (vendor_mode == mcv_pkg::MODE_LAYOUT1) begin
            if (view.signature != cpu_signature) begin
                status = mcv_pkg::ST_SIGNATURE;
            end else if ((view.platform[7:0] & platform_mask) == 8'd0) begin
                status = mcv_pkg::ST_PLATFORM;
            end else if (size_bad) begin
                status = mcv_pkg::ST_SIZE;
            end else if (view.truncated) begin
                status = mcv_pkg::ST_TRUNCATED;
            end else if (!view.sum_zero) begin
                status = mcv_pkg::ST_CHECKSUM;
            end else if (!newer) begin
                status = mcv_pkg::ST_REJECT;
            end
        end else begin
            if (view.platform[15:0] != expected_id) begin
                status = mcv_pkg::ST_SIGNATURE;
            end else if (!newer) begin
                status = mcv_pkg::ST_REJECT;
            end
        end
    end

endmodule

// ----- tb/tb_microcode_image_validator_unit.sv -----
// Self-checking bench for microcode_image_validator_unit: streams update images word by word
// and checks each verdict beat against a bit-exact predictor of the header and checksum rules.
// Depends on mcv_pkg and the validator RTL only.
module tb_microcode_image_validator_unit;
    import mcv_pkg::*;

    localparam int          IMG_BYTES       = 2048;
    localparam int          COUNT_CAP       = IMG_BYTES / 4 + 1;
    localparam int          WATCHDOG_CYCLES = 5000;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          HOLD_CYCLES     = 120;
    localparam int          IDLE_PCT        = 18;
    localparam logic [1:0]  MODE_SPARE      = 2'd3;

    typedef struct {
        logic [31:0] word;
        logic        is_last;
    } word_beat_t;

    typedef struct {
        logic        ok;
        logic [3:0]  status;
        logic [31:0] revision;
    } verdict_t;

    typedef enum {STY_NORMAL, STY_CALM, STY_PRESSURE} phase_style_t;

    typedef enum {
        FL_VERSION, FL_SIGNATURE, FL_PLATFORM, FL_PAYLOAD_LEN, FL_ZERO_PAYLOAD_LEN,
        FL_TRUNCATED, FL_STALE, FL_HUGE_SPAN, FL_TINY_SPAN, FL_SIZE_EDGE, FL_SHORT,
        FL_NONE
    } flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    microcode_image_validator_unit #(.MAX_IMAGE_BYTES(IMG_BYTES)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register shadows
    logic [1:0]  reg_mode;
    logic [31:0] reg_signature;
    logic [7:0]  reg_platform;
    logic [31:0] reg_installed;

    // per-image predictor state
    logic [13:0] words_seen;
    logic [31:0] img_sum;
    logic [31:0] img_span;
    logic [31:0] img_hdr [HDR_WORDS];

    word_beat_t   word_q [$];
    verdict_t     verdict_q [$];
    logic [31:0]  img [$];
    int unsigned  phase_words;
    phase_style_t phase_style = STY_NORMAL;
    logic         in_taken    = 1'b0;
    int unsigned  mismatches  = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  rx_hold_left = 0;
    logic         rx_hold_done = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [15:0] proc_rev_id(input logic [31:0] sig);
        logic [31:0] fam;
        logic [31:0] mdl;
        logic [31:0] id;
        fam = {28'd0, sig[11:8]};
        mdl = {28'd0, sig[7:4]};
        if (fam >= 32'd15) fam = fam + {24'd0, sig[27:20]};
        if (fam >= 32'd15 || (fam == 32'd6 && mdl >= 32'd15))
            mdl = mdl + {24'd0, sig[19:16], 4'd0};
        id = (fam << 12) | (mdl << 4) | {28'd0, sig[3:0]};
        return id[15:0];
    endfunction

    task automatic clear_image_state();
        words_seen = '0;
        img_sum    = '0;
        img_span   = DEFAULT_SPAN_BYTES >> 2;
        foreach (img_hdr[k]) img_hdr[k] = '0;
    endtask

    function automatic logic [3:0] judge_image();
        logic [31:0] ds;
        logic [31:0] ts;
        ds = img_hdr[HW_PAYLOAD_LEN];
        ts = img_hdr[HW_IMAGE_LEN];
        if (reg_mode != MODE_LAYOUT1 && reg_mode != MODE_LAYOUT2) return ST_REJECT;
        if (words_seen < MIN_WORDS) return ST_SHORT;
        if (img_hdr[HW_VERSION] != HDR_VERSION_ONE) return ST_VERSION;
        if (reg_mode == MODE_LAYOUT1) begin
            if (img_hdr[HW_SIGNATURE] != reg_signature) return ST_SIGNATURE;
            if ((img_hdr[HW_PLATFORM][7:0] & reg_platform) == 8'd0) return ST_PLATFORM;
            if (ds == 32'd0) begin
                if (ts < IMAGE_LEN_MIN || ts > IMAGE_LEN_MAX) return ST_SIZE;
            end else if (ds < PAYLOAD_LEN_MIN || ds > PAYLOAD_LEN_MAX) begin
                return ST_SIZE;
            end
            if (img_span > IMG_BYTES / 4 || {18'd0, words_seen} < img_span)
                return ST_TRUNCATED;
            if (img_sum != 32'd0) return ST_CHECKSUM;
        end else begin
            if (img_hdr[HW_PLATFORM][15:0] != proc_rev_id(reg_signature)) return ST_SIGNATURE;
        end
        if (img_hdr[HW_REVISION] <= reg_installed) return ST_REJECT;
        return ST_OK;
    endfunction

    task automatic absorb_image_word(input logic [31:0] w, input logic is_last);
        verdict_t    v;
        int unsigned n;
        if (words_seen < HDR_WORDS) begin
            img_hdr[words_seen] = w;
            if (words_seen == HW_IMAGE_LEN) begin
                img_span = ((w != 32'd0) ? w : DEFAULT_SPAN_BYTES) >> 2;
                n = (img_span < HDR_WORDS) ? img_span : HDR_WORDS;
                img_sum = '0;
                for (int k = 0; k < n; k++) img_sum = img_sum + img_hdr[k];
            end
        end else if ({18'd0, words_seen} < img_span) begin
            img_sum = img_sum + w;
        end
        if (words_seen < COUNT_CAP) words_seen = words_seen + 14'd1;
        if (is_last) begin
            v.status   = judge_image();
            v.ok       = (v.status == ST_OK);
            v.revision = img_hdr[HW_REVISION];
            verdict_q.push_back(v);
            clear_image_state();
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        verdict_t want;
        if (!aresetn) begin
            reg_mode      = MODE_NONE;
            reg_signature = '0;
            reg_platform  = '0;
            reg_installed = '0;
            clear_image_state();
            in_taken    <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VENDOR_MODE:        reg_mode      = cfg_wdata[1:0];
                    REG_CPU_SIGNATURE:      reg_signature = cfg_wdata;
                    REG_PLATFORM_MASK:      reg_platform  = cfg_wdata[7:0];
                    REG_INSTALLED_REVISION: reg_installed = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) absorb_image_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none pending", m_tdata[36:5], '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.ok)
                        report_mismatch("accepted", {31'd0, m_tdata[0]}, {31'd0, want.ok});
                    if (m_tdata[4:1] !== want.status)
                        report_mismatch("status", {28'd0, m_tdata[4:1]}, {28'd0, want.status});
                    if (m_tdata[36:5] !== want.revision)
                        report_mismatch("revision", m_tdata[36:5], want.revision);
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("FAIL microcode_image_validator_unit");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : feed_words
        word_beat_t nxt;
        if (!s_tvalid || in_taken) begin
            if (word_q.size() != 0 &&
                (phase_style == STY_CALM || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.word;
                s_tlast  <= nxt.is_last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drain_verdicts
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else if (phase_style == STY_PRESSURE && !rx_hold_done) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= (phase_style == STY_CALM) || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_all_verdicts();
        do @(negedge aclk); while (word_q.size() != 0 || verdict_q.size() != 0 || s_tvalid);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [31:0] sig,
                              input logic [7:0] pmask, input logic [31:0] inst,
                              input phase_style_t sty);
        phase_style = sty;
        write_reg(REG_VENDOR_MODE, {30'd0, mode});
        write_reg(REG_CPU_SIGNATURE, sig);
        write_reg(REG_PLATFORM_MASK, {24'd0, pmask});
        write_reg(REG_INSTALLED_REVISION, inst);
        phase_words = 0;
    endtask

    task automatic emit_image();
        word_beat_t b;
        foreach (img[i]) begin
            b.word    = img[i];
            b.is_last = (i == img.size() - 1);
            word_q.push_back(b);
        end
        phase_words += img.size();
    endtask

    task automatic fill_random(input int unsigned n);
        img.delete();
        repeat (n) img.push_back($urandom);
    endtask

    task automatic cut_short();
        int unsigned keep;
        keep = $urandom_range(11, 1);
        while (img.size() > keep) img.delete(img.size() - 1);
    endtask

    function automatic logic [31:0] pick_rev(input bit newer);
        if (newer && reg_installed != 32'hFFFF_FFFF)
            return $urandom_range(32'hFFFF_FFFF, reg_installed + 32'd1);
        return $urandom_range(reg_installed, 32'd0);
    endfunction

    // force the words inside the checksum span to sum to zero
    task automatic seal_checksum();
        logic [31:0] s;
        int unsigned span;
        int unsigned lim;
        if (img.size() <= HDR_WORDS) return;
        span = ((img[HW_IMAGE_LEN] != 0) ? img[HW_IMAGE_LEN] : DEFAULT_SPAN_BYTES) >> 2;
        if (span <= HDR_WORDS) return;
        lim = (span < img.size()) ? span : img.size();
        s = '0;
        for (int k = 0; k < lim; k++) if (k != HDR_WORDS) s = s + img[k];
        img[HDR_WORDS] = -s;
    endtask

    task automatic build_layout1(input int unsigned n, input logic [31:0] ds,
                                 input logic [31:0] ts, input logic [31:0] rev);
        fill_random(n);
        img[HW_VERSION]     = HDR_VERSION_ONE;
        img[HW_REVISION]    = rev;
        img[HW_SIGNATURE]   = reg_signature;
        img[HW_PLATFORM]    = $urandom | {24'd0, reg_platform};
        img[HW_PAYLOAD_LEN] = ds;
        img[HW_IMAGE_LEN]   = ts;
    endtask

    function automatic flaw_t pick_flaw();
        int unsigned k;
        k = $urandom_range(19);
        return (k < FL_NONE) ? flaw_t'(k) : FL_NONE;
    endfunction

    task automatic queue_layout1_image();
        int unsigned n;
        int unsigned span;
        n    = $urandom_range(40, 12);
        span = $urandom_range(n, 10);
        build_layout1(n, $urandom_range(PAYLOAD_LEN_MAX, PAYLOAD_LEN_MIN),
                      span * 4 + $urandom_range(3), pick_rev(1));
        case (pick_flaw())
            FL_VERSION:   img[HW_VERSION] = $urandom_range(1) ? 32'd0 : $urandom;
            FL_SIGNATURE: img[HW_SIGNATURE] ^= 32'd1 << $urandom_range(31);
            FL_PLATFORM:  img[HW_PLATFORM] &= ~{24'd0, reg_platform};
            FL_PAYLOAD_LEN: begin
                case ($urandom_range(2))
                    0:       img[HW_PAYLOAD_LEN] = PAYLOAD_LEN_MIN - 32'd1;
                    1:       img[HW_PAYLOAD_LEN] = PAYLOAD_LEN_MAX + 32'd1;
                    default: img[HW_PAYLOAD_LEN] = $urandom;
                endcase
            end
            FL_ZERO_PAYLOAD_LEN: begin
                img[HW_PAYLOAD_LEN] = '0;
                case ($urandom_range(4))
                    0:       img[HW_IMAGE_LEN] = IMAGE_LEN_MIN - 32'd4;
                    1:       img[HW_IMAGE_LEN] = IMAGE_LEN_MAX + 32'd4;
                    2:       img[HW_IMAGE_LEN] = '0;
                    3:       img[HW_IMAGE_LEN] = IMAGE_LEN_MAX;
                    default: img[HW_IMAGE_LEN] = $urandom_range(IMAGE_LEN_MAX, IMAGE_LEN_MIN);
                endcase
            end
            FL_TRUNCATED: img[HW_IMAGE_LEN] = (n + $urandom_range(20, 1)) * 4;
            FL_STALE:     img[HW_REVISION] = pick_rev(0);
            FL_HUGE_SPAN: img[HW_IMAGE_LEN] = $urandom_range(32'hFFFF_FFFF, IMAGE_LEN_MAX + 4);
            FL_TINY_SPAN: img[HW_IMAGE_LEN] = $urandom_range(39, 1);
            FL_SIZE_EDGE: img[HW_PAYLOAD_LEN] = $urandom_range(1) ? PAYLOAD_LEN_MIN
                                                                  : PAYLOAD_LEN_MAX;
            FL_SHORT:     cut_short();
            default: ;
        endcase
        seal_checksum();
        if ($urandom_range(11) == 0 && img.size() > HDR_WORDS)
            img[HDR_WORDS] ^= 32'd1 << $urandom_range(31);
        emit_image();
    endtask

    task automatic queue_layout2_image();
        fill_random($urandom_range(30, 12));
        img[HW_VERSION]  = HDR_VERSION_ONE;
        img[HW_REVISION] = pick_rev(1);
        img[HW_PLATFORM] = ($urandom & 32'hFFFF_0000) | {16'd0, proc_rev_id(reg_signature)};
        case (pick_flaw())
            FL_VERSION:   img[HW_VERSION] = $urandom_range(1) ? 32'd0 : $urandom;
            FL_SIGNATURE: img[HW_PLATFORM] ^= 32'd1 << $urandom_range(15);
            FL_STALE:     img[HW_REVISION] = pick_rev(0);
            FL_SHORT:     cut_short();
            default: ;
        endcase
        emit_image();
    endtask

    task automatic queue_random_image();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) begin
            fill_random($urandom_range(14, 1));
            if ($urandom_range(1)) img[HW_VERSION] = HDR_VERSION_ONE;
            emit_image();
        end else if (reg_mode == MODE_LAYOUT2 || (reg_mode != MODE_LAYOUT1 && r < 60)) begin
            queue_layout2_image();
        end else begin
            queue_layout1_image();
        end
    endtask

    task automatic random_part(input int unsigned budget);
        while (phase_words < budget) queue_random_image();
        wait_all_verdicts();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(MODE_LAYOUT1, $urandom, 8'h04, 32'h0000_1000, STY_NORMAL);
        img.delete();
        img.push_back(32'hFFFF_FFFF);
        emit_image();
        build_layout1(12, PAYLOAD_LEN_MIN, 32'd48, pick_rev(1));
        img[10] = 32'd0;
        img[11] = 32'hFFFF_FFFF;
        seal_checksum();
        emit_image();
        build_layout1(11, PAYLOAD_LEN_MAX, 32'd44, pick_rev(1));
        emit_image();
        wait_all_verdicts();

        // full default span, running past the word-count ceiling
        build_layout1(COUNT_CAP + 3, PAYLOAD_LEN_MIN, 32'd0, pick_rev(1));
        seal_checksum();
        emit_image();
        phase_words = 0;
        random_part(50);

        set_config(MODE_LAYOUT2, 32'h0000_0F00 | ($urandom & 32'hFFFF_F0FF), 8'h00,
                   32'h0, STY_CALM);
        random_part(40);

        set_config(MODE_LAYOUT2, ($urandom & 32'hFFFF_F00F) | 32'h0000_06F0, 8'h00,
                   32'hFFFF_FFFE, STY_NORMAL);
        random_part(30);

        set_config(MODE_LAYOUT1, 32'hFFFF_FFFF, 8'h80, 32'h0, STY_PRESSURE);
        repeat (40) begin
            img.delete();
            img.push_back($urandom);
            emit_image();
        end
        random_part(50);

        set_config(MODE_LAYOUT1, 32'h0, 8'h01, $urandom, STY_NORMAL);
        random_part(30);

        set_config(MODE_NONE, $urandom, 8'h10, $urandom, STY_NORMAL);
        random_part(15);

        set_config(MODE_SPARE, $urandom, 8'h02, $urandom, STY_NORMAL);
        random_part(15);

        set_config(MODE_LAYOUT1, $urandom, 8'h00, 32'hFFFF_FFFF, STY_NORMAL);
        random_part(20);

        set_config(MODE_LAYOUT2, $urandom, 8'h00, $urandom, STY_NORMAL);
        random_part(30);

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASS microcode_image_validator_unit");
        end else begin
            $display("FAIL microcode_image_validator_unit");
        end
        $finish;
    end

endmodule
